// ----- hdl/hsh_pkg.sv -----
// Shared constants for the hue/saturation histogram block.
// No dependencies; imported by the share divider and the top level.
`default_nettype none

package hsh_pkg;

	localparam int SHARE_FRAC_BITS = 16;
	localparam int SHARE_W         = SHARE_FRAC_BITS + 1;
	localparam int BIN_IDX_W       = 3;
	localparam int TOTAL_OUT_W     = 20;
	localparam int BINS_W          = 4;
	localparam int MODE_W          = 2;
	localparam int CFG_INDEX_W     = 2;

	localparam int HUE_RANGE       = 180;
	localparam logic [7:0] HUE_TOP  = 8'd179;
	localparam logic [7:0] CHAN_TOP = 8'd255;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_BINS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAT_BINS    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SKIP_BW_NZ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MASK       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SKIP_BW    = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/hsh_share_div.sv -----
// Restoring divider for bin shares: quotient = floor(count * 2^16 / total).
// One quotient bit per cycle. Depends on hsh_pkg.
`default_nettype none

module hsh_share_div import hsh_pkg::*; #(
	parameter int COUNT_BITS = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COUNT_BITS-1:0] dividend,
	input  wire logic [COUNT_BITS-1:0] divisor,
	output logic                       done,
	output logic [SHARE_W-1:0]         quotient
);

	localparam int CNT_W = $clog2(SHARE_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [COUNT_BITS:0] rem_q;
	logic [SHARE_W-1:0]  quo_q;
	logic                ge;
	logic [COUNT_BITS:0] diff;

	// The count never exceeds the total, so the partial remainder stays below twice the divisor.
	assign ge   = rem_q >= {1'b0, divisor};
	assign diff = ge ? (rem_q - {1'b0, divisor}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SHARE_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {diff[COUNT_BITS-1:0], 1'b0};
			quo_q <= {quo_q[SHARE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- hdl/hue_sat_histogram_unit.sv -----
// Top level of the hue/saturation histogram: filter, bin memory and readout sequencer.
// Depends on hsh_pkg and hsh_share_div.
//
// Usage:
// Pixels enter on the in_* channel, one beat per pixel, at up to one beat per cycle.
// Each kept pixel does a read-modify-write of its bin in a 64-entry synchronous RAM;
// a one-entry bypass covers back-to-back hits on the same bin.
// A beat with last set closes the region. The block then stops taking pixels and,
// for every bin in use (hue-major), reads the count, runs a shift-subtract divide
// and offers one result beat on out_*, held while the receiver keeps out_ready
// low; the result stays stable until taken. After the final bin, a clearing sweep
// writes zero to all bin entries, one per cycle, and the total is reset.
// Reset runs the same sweep before the first pixel is taken; in_ready stays low
// meanwhile. Registers are written on the cfg_* channel, which is always ready,
// and should only be written while no region is being emitted.
`default_nettype none

module hue_sat_histogram_unit import hsh_pkg::*; #(
	parameter int MAX_HUE_BINS = 8,
	parameter int MAX_SAT_BINS = 8,
	parameter int COUNT_BITS   = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [BINS_W-1:0]      cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             blue,
	input  wire logic [7:0]             green,
	input  wire logic [7:0]             red,
	input  wire logic [7:0]             hue,
	input  wire logic [7:0]             sat,
	input  wire logic                   mask_ok,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [BIN_IDX_W-1:0]        hue_bin,
	output logic [BIN_IDX_W-1:0]        sat_bin,
	output logic [SHARE_W-1:0]          share,
	output logic [TOTAL_OUT_W-1:0]      pixel_total,
	output logic                        empty_res,
	output logic                        last_bin
);

	localparam int CELLS  = MAX_HUE_BINS * MAX_SAT_BINS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] mem [CELLS];

	logic [2:0]            state_q;
	logic [MODE_W-1:0]     mode_q;
	logic [BINS_W-1:0]     hue_bins_q;
	logic [BINS_W-1:0]     sat_bins_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [CELL_W-1:0]     clr_q;
	logic [BIN_IDX_W-1:0]  ei_q;
	logic [BIN_IDX_W-1:0]  ej_q;
	logic [COUNT_BITS-1:0] rd_q;

	logic                  v_s1;
	logic [CELL_W-1:0]     cell_s1;
	logic                  fwd_v_q;
	logic [CELL_W-1:0]     fwd_cell_q;
	logic [COUNT_BITS-1:0] fwd_val_q;

	logic [BINS_W-1:0]     hb_eff;
	logic [BINS_W-1:0]     sb_eff;
	logic [7:0]            hue_c;
	logic                  black_white;
	logic                  keep;
	logic [11:0]           prod_h;
	logic [10:0]           prod_s;
	logic [BIN_IDX_W-1:0]  hi;
	logic [BIN_IDX_W-1:0]  si;
	logic [CELL_W-1:0]     cell_s0;
	logic [CELL_W-1:0]     emit_cell;
	logic [CELL_W-1:0]     rd_addr;
	logic                  in_acc;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  we;
	logic [CELL_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  bin_end_j;
	logic                  bin_end;
	logic                  div_start;
	logic                  div_done;
	logic [SHARE_W-1:0]    div_quo;

	function automatic logic [BINS_W-1:0] clamp_bins(input logic [BINS_W-1:0] v,
			input logic [BINS_W-1:0] top);
		logic [BINS_W-1:0] r;
		begin
			r = v;
			if (v == '0) begin
				r = BINS_W'(1);
			end else if (v > top) begin
				r = top;
			end
			return r;
		end
	endfunction

	assign hb_eff = clamp_bins(hue_bins_q, BINS_W'(MAX_HUE_BINS));
	assign sb_eff = clamp_bins(sat_bins_q, BINS_W'(MAX_SAT_BINS));

	// Pixel filter and bin index.
	assign hue_c       = (hue > HUE_TOP) ? HUE_TOP : hue;
	assign black_white = ((blue == '0) && (green == '0) && (red == '0)) ||
		((blue == CHAN_TOP) && (green == CHAN_TOP) && (red == CHAN_TOP));

	always_comb begin
		case (mode_q)
			MODE_MASK:    keep = mask_ok && (hue_c != '0) && (sat != '0);
			MODE_SKIP_BW: keep = !black_white;
			default:      keep = !black_white && (hue_c != '0) && (sat != '0);
		endcase
	end

	assign prod_h = 12'(hue_c) * 12'(hb_eff);
	assign prod_s = 11'(sat) * 11'(sb_eff);
	assign si     = prod_s[10:8];

	// The hue bin is the number of multiples of 180 that the product reaches.
	always_comb begin
		hi = '0;
		for (int k = 1; k < MAX_HUE_BINS; k++) begin
			if (prod_h >= 12'(HUE_RANGE * k)) begin
				hi = hi + 1'b1;
			end
		end
	end

	assign cell_s0   = CELL_W'(int'(hi) * MAX_SAT_BINS + int'(si));
	assign emit_cell = CELL_W'(int'(ei_q) * MAX_SAT_BINS + int'(ej_q));
	assign rd_addr   = (state_q == ST_RUN) ? cell_s0 : emit_cell;

	assign in_ready  = (state_q == ST_RUN);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Read-modify-write with a bypass for the entry written on the previous edge.
	assign old_cnt = (fwd_v_q && (fwd_cell_q == cell_s1)) ? fwd_val_q : rd_q;
	assign new_cnt = (old_cnt == COUNT_TOP) ? COUNT_TOP : (old_cnt + 1'b1);

	assign we      = (state_q == ST_CLEAR) || v_s1;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : cell_s1;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : new_cnt;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		cell_s1    <= cell_s0;
		fwd_cell_q <= cell_s1;
		fwd_val_q  <= new_cnt;
	end

	assign bin_end_j = ({1'b0, ej_q} == (sb_eff - 1'b1));
	assign bin_end   = bin_end_j && ({1'b0, ei_q} == (hb_eff - 1'b1));
	assign div_start = (state_q == ST_LOAD);

	hsh_share_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rd_q),
		.divisor (total_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			mode_q     <= MODE_SKIP_BW_NZ;
			hue_bins_q <= BINS_W'(8);
			sat_bins_q <= BINS_W'(8);
			total_q    <= '0;
			clr_q      <= '0;
			ei_q       <= '0;
			ej_q       <= '0;
			v_s1       <= 1'b0;
			fwd_v_q    <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
			v_s1    <= in_acc && keep;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILTER_MODE: mode_q     <= cfg_data[MODE_W-1:0];
					REG_HUE_BINS:    hue_bins_q <= cfg_data;
					REG_SAT_BINS:    sat_bins_q <= cfg_data;
					default:         ;
				endcase
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_W'(CELLS - 1)) begin
						clr_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (in_acc) begin
						if (keep && (total_q != COUNT_TOP)) begin
							total_q <= total_q + 1'b1;
						end
						if (last) begin
							ei_q    <= '0;
							ej_q    <= '0;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: state_q <= ST_READ;
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (bin_end) begin
							total_q <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							if (bin_end_j) begin
								ej_q <= '0;
								ei_q <= ei_q + 1'b1;
							end else begin
								ej_q <= ej_q + 1'b1;
							end
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign out_valid   = (state_q == ST_OUT);
	assign hue_bin     = ei_q;
	assign sat_bin     = ej_q;
	assign empty_res   = (total_q == '0);
	assign share       = empty_res ? '0 : div_quo;
	assign pixel_total = TOTAL_OUT_W'(total_q);
	assign last_bin    = bin_end;

endmodule

`default_nettype wire
